/* rtl/c3g_pkg.sv */
package c3g_pkg;

   // Fixed field widths of the stream and configuration interface.
   localparam int PIX_BITS       = 8;
   localparam int IDX_BITS       = 10;
   localparam int CFG_SIZE_BITS  = 11;
   localparam int KROW_BITS      = 24;
   localparam int CSR_INDEX_BITS = 3;

   // Result queue holds whole per-pixel bundles of up to three results.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = 3;
   localparam int QCNT_BITS   = 4;

   localparam logic [CFG_SIZE_BITS-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_SIZE_BITS-1:0] HEIGHT_RESET = 11'd1024;
   localparam logic [KROW_BITS-1:0]     KROW0_RESET  = 24'h000100;
   localparam logic [KROW_BITS-1:0]     KROW1_RESET  = 24'hFF05FF;
   localparam logic [KROW_BITS-1:0]     KROW2_RESET  = 24'h00FF00;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_KERNEL_ROW0  = 3'd2,
      CSR_KERNEL_ROW1  = 3'd3,
      CSR_KERNEL_ROW2  = 3'd4
   } csr_index_type;

   typedef logic [PIX_BITS-1:0] pix_type;
   typedef logic [IDX_BITS-1:0] idx_type;

   // Per-pixel control travelling down the pipeline.
   typedef struct packed {
      pix_type pixel;
      logic    emit_main;
      logic    main_border;
      logic    emit_right;
      logic    emit_own;
      idx_type row;
      idx_type row_m1;
      idx_type col;
      idx_type col_m1;
   } item_type;

   typedef struct packed {
      pix_type pixel;
      idx_type row;
      idx_type col;
      logic    border;
   } res_type;

   typedef struct packed {
      res_type [2:0] res;
      logic [1:0]    count;
   } bundle_type;

endpackage

/* rtl/c3g_ram.sv */
module c3g_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/c3g_mac.sv */
module c3g_mac
   import c3g_pkg::*;
#(
   parameter int COEF_BITS = 8
) (
   input  logic                      clock,
   input  pix_type [8:0]             win,
   input  logic [2:0][KROW_BITS-1:0] kernel,
   output pix_type                   filt
);

   localparam int CB   = (COEF_BITS < PIX_BITS) ? COEF_BITS : PIX_BITS;
   localparam int CMAX = (1 << (CB - 1)) - 1;
   localparam int CMIN = -(1 << (CB - 1));
   localparam int PW   = PIX_BITS + 1 + CB;
   localparam int SW   = PW + 4;

   logic signed [CB-1:0] coef [9];
   logic signed [PW-1:0] prod_in [9];
   logic signed [PW-1:0] prod_ff [9];
   logic signed [SW-1:0] acc;

   // Coefficients come from static configuration, so they settle long before use.
   always_comb begin
      logic signed [PIX_BITS-1:0] raw;
      for (int k = 0; k < 9; k++) begin
         raw = signed'(kernel[k / 3][8 * (k % 3) +: 8]);
         if (int'(raw) > CMAX) begin
            coef[k] = CB'(CMAX);
         end else if (int'(raw) < CMIN) begin
            coef[k] = CB'(CMIN);
         end else begin
            coef[k] = CB'(raw);
         end
         prod_in[k] = PW'(signed'({1'b0, win[k]})) * PW'(coef[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < 9; k++) begin
         acc = acc + SW'(prod_ff[k]);
      end
      if (acc < 0) begin
         filt = '0;
      end else if (acc > SW'(255)) begin
         filt = '1;
      end else begin
         filt = acc[PIX_BITS-1:0];
      end
   end

endmodule

/* rtl/c3g_rsp_queue.sv */
module c3g_rsp_queue
   import c3g_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bundle_type           push_bundle,
   output logic [QCNT_BITS-1:0] level,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output res_type              rsp_res,
   output logic                 rsp_last
);

   bundle_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] head_ff, head_in;
   logic [QPTR_BITS-1:0] tail_ff, tail_in;
   logic [QCNT_BITS-1:0] level_ff, level_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 beat;
   logic                 pop;

   assign rsp_valid = (level_ff != '0);
   assign rsp_res   = slots_ff[head_ff].res[idx_ff];
   assign rsp_last  = ((idx_ff + 2'd1) == slots_ff[head_ff].count);
   assign beat      = rsp_valid && rsp_ready;
   assign pop       = beat && rsp_last;
   assign level     = level_ff;

   always_comb begin
      head_in  = pop ? head_ff + QPTR_BITS'(1) : head_ff;
      tail_in  = push ? tail_ff + QPTR_BITS'(1) : tail_ff;
      level_in = level_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
      idx_in   = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (beat) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
         idx_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[tail_ff] <= push_bundle;
      end
   end

endmodule

/* rtl/conv3x3_gray_saturating_core.sv */
// 3x3 saturating convolution over a raster-order stream of 8-bit grayscale
// pixels. Each accepted req beat carries one pixel (req_tuser marks the first
// pixel of a frame) and causes zero to three rsp beats: the filtered (or left
// border) pixel one row up and one column left, the right border copy of that
// row when the input sits in the last column, and a copy of the input itself
// when it lies in the first or last row. rsp_tlast marks the final beat caused
// by one input pixel, and rsp_tuser flags an unfiltered border copy. When not
// stalled, the block takes one pixel per clock and gives one rsp beat per
// clock; each pixel passes the counter step, line buffer read, window shift,
// products, sum and clamp before it is queued. Results wait in an eight-entry
// queue of per-pixel bundles, and req_tready drops when the queue plus the
// pixels still in the pipeline would fill it, so a stalled rsp side backs up
// to the req side after a few beats. The two line buffers are single-port-write
// RAMs of MAX_WIDTH words; a fill count marks the columns written since reset,
// so no clearing pass is needed and the block accepts pixels right out of
// reset. Width and height are clamped to 3..MAX, and coefficients saturate to
// the signed COEF_BITS range. Configuration is written through the csr port;
// the user must do so only while the stream is idle; the block does not enforce it.
module conv3x3_gray_saturating_core
   import c3g_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COEF_BITS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input stream. tdata: pixel_in[7:0]. tuser: frame_start[0].
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tuser,
   // Result stream. tdata: pixel_out[7:0], out_row[17:8], out_col[27:18],
   // zero[31:28]. tuser: is_border[0]. tlast: last_of_run.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast,
   // Configuration write port.
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [KROW_BITS-1:0]      csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int FW  = $clog2(MAX_WIDTH + 1);
   localparam int SZW = (CFG_SIZE_BITS > FW) ? CFG_SIZE_BITS : FW;
   localparam int SZH = (CFG_SIZE_BITS > $clog2(MAX_HEIGHT + 1)) ?
                        CFG_SIZE_BITS : $clog2(MAX_HEIGHT + 1);

   // Configuration registers.
   logic [CFG_SIZE_BITS-1:0]  image_width_ff;
   logic [CFG_SIZE_BITS-1:0]  image_height_ff;
   logic [2:0][KROW_BITS-1:0] kernel_ff;

   // Position counters.
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Accept stage.
   logic          accept;
   logic [SZW-1:0] w_eff;
   logic [SZH-1:0] h_eff;
   logic [CW-1:0]  col_a;
   logic [RW-1:0]  row_a;
   item_type       item_a;
   logic           haz_a;
   logic           ok_a;

   // Line buffer stage.
   logic           b_valid_ff;
   item_type       b_item_ff;
   logic [CW-1:0]  b_col_ff;
   logic           b_haz_ff;
   logic           b_ok_ff;
   pix_type        last_px_ff;
   pix_type        last_prev_ff;
   logic [FW-1:0]  fill_ff;
   pix_type        prev_rd;
   pix_type        prev2_rd;
   pix_type        prev_b;
   pix_type        prev2_b;
   pix_type [8:0]  window_ff;

   // Product stage and result stage.
   logic           c_valid_ff;
   item_type       c_item_ff;
   logic           d_valid_ff;
   item_type       d_item_ff;
   pix_type        d_win4_ff;
   pix_type        d_win5_ff;
   pix_type        filt;

   res_type [2:0]  cand;
   logic [2:0]     cand_valid;
   bundle_type     bundle;
   logic [1:0]     n_res;
   logic           push;

   logic [QCNT_BITS-1:0] level;
   logic [QCNT_BITS-1:0] occupancy;
   res_type              rsp_res;

   // A new pixel is taken only if its bundle is sure to find room in the
   // queue, counting the pixels already in flight.
   assign occupancy  = level + QCNT_BITS'(b_valid_ff) + QCNT_BITS'(c_valid_ff)
                       + QCNT_BITS'(d_valid_ff);
   assign req_tready = (occupancy < QCNT_BITS'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         kernel_ff[0]    <= KROW0_RESET;
         kernel_ff[1]    <= KROW1_RESET;
         kernel_ff[2]    <= KROW2_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[CFG_SIZE_BITS-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[CFG_SIZE_BITS-1:0];
            end
            CSR_KERNEL_ROW0: begin
               kernel_ff[0] <= csr_wdata;
            end
            CSR_KERNEL_ROW1: begin
               kernel_ff[1] <= csr_wdata;
            end
            CSR_KERNEL_ROW2: begin
               kernel_ff[2] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Position of the incoming pixel and the counters for the next one. A size
   // that shrank below the stored position moves it on to the next row, and
   // a row past the height wraps to the top of the frame.
   always_comb begin
      logic [SZW-1:0] cw;
      logic [SZH-1:0] rh;
      logic [SZW-1:0] col_p1;
      logic [SZH-1:0] row_p1;

      w_eff = SZW'(image_width_ff);
      if (w_eff < SZW'(3)) begin
         w_eff = SZW'(3);
      end else if (w_eff > SZW'(MAX_WIDTH)) begin
         w_eff = SZW'(MAX_WIDTH);
      end
      h_eff = SZH'(image_height_ff);
      if (h_eff < SZH'(3)) begin
         h_eff = SZH'(3);
      end else if (h_eff > SZH'(MAX_HEIGHT)) begin
         h_eff = SZH'(MAX_HEIGHT);
      end

      cw = SZW'(col_ff);
      rh = SZH'(row_ff);
      if (req_tuser) begin
         cw = '0;
         rh = '0;
      end else begin
         if (cw >= w_eff) begin
            cw = '0;
            rh = rh + SZH'(1);
         end
         if (rh >= h_eff) begin
            rh = '0;
         end
      end
      col_a = CW'(cw);
      row_a = RW'(rh);

      col_p1 = cw + SZW'(1);
      row_p1 = rh + SZH'(1);
      if (col_p1 >= w_eff) begin
         col_in = '0;
         row_in = (row_p1 >= h_eff) ? '0 : RW'(row_p1);
      end else begin
         col_in = CW'(col_p1);
         row_in = row_a;
      end

      item_a.pixel       = req_tdata[PIX_BITS-1:0];
      item_a.emit_main   = (row_a >= RW'(2)) && (col_a >= CW'(1));
      item_a.main_border = (col_a == CW'(1));
      item_a.emit_right  = (row_a >= RW'(2)) && (cw == w_eff - SZW'(1));
      item_a.emit_own    = (row_a == '0) || (rh == h_eff - SZH'(1));
      item_a.row         = IDX_BITS'(row_a);
      item_a.row_m1      = IDX_BITS'(row_a - RW'(1));
      item_a.col         = IDX_BITS'(col_a);
      item_a.col_m1      = IDX_BITS'(col_a - CW'(1));
   end

   // The line buffer write for the pixel one beat ahead lands in the same
   // cycle as this read; a read of that same column takes the written words.
   assign haz_a = b_valid_ff && (b_col_ff == col_a);
   assign ok_a  = (FW'(col_a) < fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         fill_ff    <= '0;
         window_ff  <= '0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         b_valid_ff <= accept;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         if (b_valid_ff) begin
            // Columns are written in order from zero, so the written set is
            // always a prefix of the line.
            if (FW'(b_col_ff) >= fill_ff) begin
               fill_ff <= FW'(b_col_ff) + FW'(1);
            end
            window_ff[0] <= window_ff[1];
            window_ff[1] <= window_ff[2];
            window_ff[3] <= window_ff[4];
            window_ff[4] <= window_ff[5];
            window_ff[6] <= window_ff[7];
            window_ff[7] <= window_ff[8];
            window_ff[2] <= prev2_b;
            window_ff[5] <= prev_b;
            window_ff[8] <= b_item_ff.pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      b_item_ff <= item_a;
      b_col_ff  <= col_a;
      b_haz_ff  <= haz_a;
      b_ok_ff   <= ok_a;
      if (b_valid_ff) begin
         last_px_ff   <= b_item_ff.pixel;
         last_prev_ff <= prev_b;
      end
      c_item_ff <= b_item_ff;
      d_item_ff <= c_item_ff;
      d_win4_ff <= window_ff[4];
      d_win5_ff <= window_ff[5];
   end

   always_comb begin
      if (b_haz_ff) begin
         prev_b  = last_px_ff;
         prev2_b = last_prev_ff;
      end else if (b_ok_ff) begin
         prev_b  = prev_rd;
         prev2_b = prev2_rd;
      end else begin
         prev_b  = '0;
         prev2_b = '0;
      end
   end

   c3g_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_prev (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (b_item_ff.pixel),
      .rd_addr (col_a),
      .rd_data (prev_rd)
   );

   c3g_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_prev2 (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (prev_b),
      .rd_addr (col_a),
      .rd_data (prev2_rd)
   );

   // Products are registered inside; the clamped sum follows combinationally from them.
   c3g_mac #(
      .COEF_BITS (COEF_BITS)
   ) u_mac (
      .clock  (clock),
      .win    (window_ff),
      .kernel (kernel_ff),
      .filt   (filt)
   );

   // Gather the results of one pixel, in output order, into a bundle.
   always_comb begin
      cand[0].pixel  = d_item_ff.main_border ? d_win4_ff : filt;
      cand[0].row    = d_item_ff.row_m1;
      cand[0].col    = d_item_ff.col_m1;
      cand[0].border = d_item_ff.main_border;
      cand[1].pixel  = d_win5_ff;
      cand[1].row    = d_item_ff.row_m1;
      cand[1].col    = d_item_ff.col;
      cand[1].border = 1'b1;
      cand[2].pixel  = d_item_ff.pixel;
      cand[2].row    = d_item_ff.row;
      cand[2].col    = d_item_ff.col;
      cand[2].border = 1'b1;
      cand_valid = {d_item_ff.emit_own, d_item_ff.emit_right, d_item_ff.emit_main};

      bundle = '0;
      n_res  = '0;
      for (int k = 0; k < 3; k++) begin
         if (cand_valid[k]) begin
            bundle.res[n_res] = cand[k];
            n_res = n_res + 2'd1;
         end
      end
      bundle.count = n_res;
   end

   assign push = d_valid_ff && (n_res != '0);

   c3g_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (bundle),
      .level       (level),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_res     (rsp_res),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, rsp_res.col, rsp_res.row, rsp_res.pixel};
   assign rsp_tuser = rsp_res.border;

endmodule

/* test/conv3x3_gray_saturating_core_tb.sv */
`timescale 1ns / 100ps

// Testbench for the 3x3 saturating grayscale convolution core.
//
// Every pixel beat that the core accepts is fed to a predictor in this file.
// The predictor keeps its own line buffers, window and row/column counters,
// and it appends the result beats that the pixel should release to a queue.
// A checker pops that queue on every accepted rsp beat and compares each
// field. Stimulus is a short directed part (reset kernel, coefficient
// extremes, frame wrap), a part with the largest and clamped frame sizes, and
// random frames under three stall mixes.
module conv3x3_gray_saturating_core_tb;
   import c3g_pkg::*;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int COEF_BITS      = 8;
   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 11;
   // Cycles to let the pipeline drain after the last expected beat; this
   // leaves a wide margin for pixels that release nothing.
   localparam int SETTLE_CYCLES  = 12;
   // Cycles with no beat on either side before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;

   // One result beat as the predictor expects it.
   typedef struct {
      pix_type pixel;
      idx_type row;
      idx_type col;
      logic    border;
      logic    last;
   } conv_beat_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [KROW_BITS-1:0]      csr_wdata = '0;

   // Predictor copy of the configuration registers.
   logic [CFG_SIZE_BITS-1:0]  cfg_width  = WIDTH_RESET;
   logic [CFG_SIZE_BITS-1:0]  cfg_height = HEIGHT_RESET;
   logic [KROW_BITS-1:0]      cfg_krow [3] = '{KROW0_RESET, KROW1_RESET, KROW2_RESET};

   // Predictor copy of the image state: two previous rows, the 3x3
   // neighborhood (row-major, newest column on the right) and the position.
   pix_type                   row_above  [MAX_WIDTH];
   pix_type                   row_above2 [MAX_WIDTH];
   pix_type                   nbhd [9];
   int unsigned               row_pos = 0;
   int unsigned               col_pos = 0;

   // Result beats released by accepted pixels and not yet seen on rsp.
   conv_beat_type             due_results [$];

   int                        send_gap_pct   = 0;
   int                        take_stall_pct = 0;
   int                        pixels_sent    = 0;
   int                        beats_checked  = 0;
   int                        csr_writes     = 0;
   int                        mismatch_count = 0;
   int                        idle_cycles    = 0;

   conv3x3_gray_saturating_core #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COEF_BITS  (COEF_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      foreach (row_above[i]) begin
         row_above[i]  = '0;
         row_above2[i] = '0;
      end
      foreach (nbhd[i]) nbhd[i] = '0;
   end

   // The result side stalls at the rate chosen for the current test.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= take_stall_pct);
   end

   // Works out the result beats that one accepted pixel releases and queues
   // them in output order: the filtered (or left border) pixel one row up and
   // one column left, then the right border copy of that row when the pixel
   // sits in the last column, then a copy of the pixel itself when it lies in
   // the first or last row.
   function automatic void convolve_pixel(input pix_type px, input logic first);
      int unsigned w;
      int unsigned h;
      int unsigned row;
      int unsigned col;
      int          sum;
      int          coef;
      int          lim;
      int          queued;
      logic signed [7:0] cbyte;
      w = (cfg_width < 3) ? 3 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      h = (cfg_height < 3) ? 3 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
      lim = 1 << (COEF_BITS - 1);
      queued = due_results.size();

      // A frame start restarts the position. Otherwise a position left out
      // of range by a smaller size steps to the next row or wraps to row 0.
      if (first) begin
         row_pos = 0;
         col_pos = 0;
      end else begin
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
      end
      row = row_pos;
      col = col_pos;

      for (int i = 0; i < 3; i++) begin
         nbhd[i*3]   = nbhd[i*3+1];
         nbhd[i*3+1] = nbhd[i*3+2];
      end
      nbhd[2] = row_above2[col];
      nbhd[5] = row_above[col];
      nbhd[8] = px;
      row_above2[col] = row_above[col];
      row_above[col]  = px;

      if (row >= 2) begin
         if (col == 1) begin
            due_results.push_back('{pixel: nbhd[4], row: idx_type'(row - 1), col: '0,
                                    border: 1'b1, last: 1'b0});
         end else if (col > 1) begin
            // Correlation, not convolution: kernel byte j weights column j.
            sum = 0;
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  cbyte = cfg_krow[i][8*j +: 8];
                  coef  = cbyte;
                  if (coef > lim - 1) coef = lim - 1;
                  if (coef < -lim) coef = -lim;
                  sum += int'(nbhd[i*3+j]) * coef;
               end
            end
            if (sum < 0) sum = 0;
            if (sum > 255) sum = 255;
            due_results.push_back('{pixel: pix_type'(sum), row: idx_type'(row - 1),
                                    col: idx_type'(col - 1), border: 1'b0, last: 1'b0});
         end
         if (col == w - 1) begin
            due_results.push_back('{pixel: nbhd[5], row: idx_type'(row - 1),
                                    col: idx_type'(w - 1), border: 1'b1, last: 1'b0});
         end
      end
      if (row == 0 || row == h - 1) begin
         due_results.push_back('{pixel: px, row: idx_type'(row), col: idx_type'(col),
                                 border: 1'b1, last: 1'b0});
      end
      if (due_results.size() > queued) due_results[$].last = 1'b1;

      col_pos = col + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = row + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic pix_type random_pixel();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return pix_type'($urandom_range(255));
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: mismatch: %s", $time, what);
   endtask

   // Compares every accepted rsp beat with the oldest queued prediction.
   always @(posedge clock) begin
      conv_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat data=%h border=%b last=%b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = due_results.pop_front();
            if (rsp_tdata[7:0] !== want.pixel || rsp_tdata[17:8] !== want.row ||
                rsp_tdata[27:18] !== want.col || rsp_tdata[31:28] !== 4'd0 ||
                rsp_tuser !== want.border || rsp_tlast !== want.last) begin
               report_mismatch($sformatf(
                  "expected px=%0d row=%0d col=%0d border=%b last=%b, got px=%0d row=%0d col=%0d pad=%h border=%b last=%b",
                  want.pixel, want.row, want.col, want.border, want.last,
                  rsp_tdata[7:0], rsp_tdata[17:8], rsp_tdata[27:18], rsp_tdata[31:28],
                  rsp_tuser, rsp_tlast));
            end
         end
      end
   end

   // Ends a run that stops moving beats in either direction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[conv3x3_gray_saturating_core] ERROR");
         $finish;
      end
   end

   // Offers one pixel beat, after a random gap, and predicts its results
   // at the edge where it is taken. Valid stays high for a following beat.
   task automatic send_pixel(input pix_type px, input logic first);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      convolve_pixel(px, first);
      pixels_sent++;
   endtask

   // Drops valid, waits for every predicted beat, then lets the pipeline
   // run dry so that pixels releasing nothing are also finished.
   task automatic settle_stream();
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register; only called while the stream is settled.
   task automatic write_csr(input csr_index_type idx, input logic [KROW_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = value[CFG_SIZE_BITS-1:0];
         CSR_IMAGE_HEIGHT: cfg_height = value[CFG_SIZE_BITS-1:0];
         CSR_KERNEL_ROW0:  cfg_krow[0] = value;
         CSR_KERNEL_ROW1:  cfg_krow[1] = value;
         CSR_KERNEL_ROW2:  cfg_krow[2] = value;
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   // A 3x3 frame through the kernel left by reset. The center pixel
   // is the only interior one and lands above 255, so it clamps high.
   task automatic test_default_kernel();
      pix_type checker_px [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                                  8'd255, 8'd0, 8'd255};
      settle_stream();
      write_csr(CSR_IMAGE_WIDTH, 24'd3);
      write_csr(CSR_IMAGE_HEIGHT, 24'd3);
      foreach (checker_px[i]) send_pixel(checker_px[i], i == 0);
      settle_stream();
   endtask

   // The most positive and most negative coefficients. The first frame
   // drives the sum far above 255, the second far below 0. The second frame
   // has no frame start, so it also relies on the counters wrapping.
   task automatic test_coef_extremes();
      pix_type two_frames [18] = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0,
                                   8'd0, 8'd0, 8'd0,
                                   8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                   8'd255, 8'd255, 8'd255};
      settle_stream();
      write_csr(CSR_KERNEL_ROW0, 24'h7F7F7F);
      write_csr(CSR_KERNEL_ROW1, 24'h807F00);
      write_csr(CSR_KERNEL_ROW2, 24'h808080);
      foreach (two_frames[i]) send_pixel(two_frames[i], i == 0);
      settle_stream();
   endtask

   // Sizes at and beyond both ends. A width register of 2047 clamps to the
   // full line and a height of 0 clamps to 3 rows; a stretch of the top row
   // goes through, which must all come back as copies. Then a tall clamped
   // frame and the exact maximum sizes get a short run each.
   task automatic test_size_extremes();
      settle_stream();
      write_csr(CSR_IMAGE_WIDTH, 24'd2047);
      write_csr(CSR_IMAGE_HEIGHT, 24'd0);
      for (int i = 0; i < 40; i++) send_pixel(random_pixel(), i == 0);
      settle_stream();
      write_csr(CSR_IMAGE_WIDTH, 24'd3);
      write_csr(CSR_IMAGE_HEIGHT, 24'd2047);
      for (int i = 0; i < 15; i++) send_pixel(random_pixel(), i == 0);
      settle_stream();
      write_csr(CSR_IMAGE_WIDTH, 24'(MAX_WIDTH));
      write_csr(CSR_IMAGE_HEIGHT, 24'(MAX_HEIGHT));
      for (int i = 0; i < 6; i++) send_pixel(random_pixel(), i == 0);
      settle_stream();
   endtask

   // Random frames under one stall mix. Most bursts are whole frames that
   // open with a frame start; some carry on from wherever the counters stand
   // after a size change; the rest are broken runs with stray frame starts.
   task automatic test_random_frames(input int count, input int send_gap,
                                     input int take_stall);
      int target;
      int w;
      int h;
      int n;
      int style;
      logic [KROW_BITS-1:0] krow;
      send_gap_pct   = send_gap;
      take_stall_pct = take_stall;
      target = pixels_sent + count;
      while (pixels_sent < target) begin
         settle_stream();
         case ($urandom_range(9))
            0: w = $urandom_range(2);
            1: w = $urandom_range(9, 14);
            default: w = $urandom_range(3, 8);
         endcase
         h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
         write_csr(CSR_IMAGE_WIDTH, 24'(w));
         write_csr(CSR_IMAGE_HEIGHT, 24'(h));
         if ($urandom_range(3) != 0) begin
            for (int r = 0; r < 3; r++) begin
               // Small coefficients keep many sums inside 0..255.
               if ($urandom_range(1)) begin
                  krow = KROW_BITS'($urandom);
               end else begin
                  for (int j = 0; j < 3; j++) krow[8*j +: 8] = 8'($urandom_range(4) - 2);
               end
               write_csr(csr_index_type'(CSR_KERNEL_ROW0 + r), krow);
            end
         end
         w = (w < 3) ? 3 : w;
         h = (h < 3) ? 3 : h;
         style = $urandom_range(99);
         if (style < 65) begin
            n = w * h * $urandom_range(1, 2);
            for (int i = 0; i < n; i++) send_pixel(random_pixel(), i == 0);
         end else if (style < 85) begin
            n = $urandom_range(1, w * h);
            for (int i = 0; i < n; i++) send_pixel(random_pixel(), 1'b0);
         end else begin
            n = $urandom_range(1, 2 * w * h);
            for (int i = 0; i < n; i++) send_pixel(random_pixel(), $urandom_range(9) == 0);
         end
      end
      settle_stream();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Light sender gaps, heavy result stalls.
      send_gap_pct   = 14;
      take_stall_pct = 82;
      test_default_kernel();
      test_coef_extremes();
      test_random_frames(100, 14, 82);

      // Heavy sender gaps, light result stalls.
      send_gap_pct   = 82;
      take_stall_pct = 14;
      test_size_extremes();
      test_random_frames(100, 82, 14);

      // Full rate on both sides.
      test_random_frames(100, 0, 0);

      settle_stream();
      $display("Sent %0d pixels and checked %0d result beats across %0d register writes,",
               pixels_sent, beats_checked, csr_writes);
      $display("covering clamped and maximum frame sizes, extreme kernels and three stall mixes.");
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("[conv3x3_gray_saturating_core] OK");
      end else begin
         $display("%0d mismatches, %0d beats still expected", mismatch_count,
                  due_results.size());
         $display("[conv3x3_gray_saturating_core] ERROR");
      end
      $finish;
   end

endmodule
